// ----- rtl/core/gnss_frame_receiver_checker_top_macros.svh -----
// Assertion macros shared by the frame receiver RTL.
`ifndef GNSS_FRAME_RECEIVER_CHECKER_TOP_MACROS_SVH
`define GNSS_FRAME_RECEIVER_CHECKER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define GFRC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("frame receiver assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define GFRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("frame receiver assertion failed");

`endif

// ----- rtl/core/gfrc_pkg.sv -----
// Package with the codes, reset values and result type of the frame receiver.
`timescale 1ns / 1ps

package gfrc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 16;
  localparam int unsigned KindW  = 3;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LENGTH  = 2'd2;

  // Configuration reset values.
  localparam logic [ByteW-1:0] SYNC_FIRST_RST  = 8'hB5;
  localparam logic [ByteW-1:0] SYNC_SECOND_RST = 8'h62;
  localparam logic [WordW-1:0] MAX_LENGTH_RST  = 16'd1024;

  // Field kind codes.
  localparam logic [KindW-1:0] KIND_HUNT    = 3'd0;
  localparam logic [KindW-1:0] KIND_SYNC    = 3'd1;
  localparam logic [KindW-1:0] KIND_CLASS   = 3'd2;
  localparam logic [KindW-1:0] KIND_ID      = 3'd3;
  localparam logic [KindW-1:0] KIND_LENGTH  = 3'd4;
  localparam logic [KindW-1:0] KIND_PAYLOAD = 3'd5;
  localparam logic [KindW-1:0] KIND_CK      = 3'd6;

  // Frame status codes.
  localparam logic [StatW-1:0] ST_PROGRESS = 2'd0;
  localparam logic [StatW-1:0] ST_GOOD     = 2'd1;
  localparam logic [StatW-1:0] ST_BAD      = 2'd2;
  localparam logic [StatW-1:0] ST_TOOLONG  = 2'd3;

  typedef struct packed {
    logic [ByteW-1:0] byte_out;
    logic [KindW-1:0] field_kind;
    logic [WordW-1:0] payload_index;
    logic [ByteW-1:0] msg_class;
    logic [ByteW-1:0] msg_id;
    logic [WordW-1:0] frame_length;
    logic             frame_end;
    logic [StatW-1:0] frame_status;
  } result_t;

endpackage

// ----- rtl/core/gnss_frame_receiver_checker_top.sv -----
// Top level of the sync-framed serial byte receiver with Fletcher checksum check.
`timescale 1ns / 1ps

// The block takes one received byte per transfer and returns one tagged
// result transfer for it, at a sustained rate of one byte per clock cycle
// while results are taken at the output. The frame phase, the captured
// header fields and the Fletcher pair are updated by one pass of logic
// (a compare against the sync and length limits plus two chained 8-bit
// adders), and the result is registered in an output register. Behind
// the output register sits one skid register, so a byte is still taken
// while a finished result waits; input ready drops only once both hold a
// result. Every byte echoes back with its field kind; the high length
// byte of an oversized frame and the second checksum byte close a frame
// and carry its status. Configuration writes take effect on the next byte.
module gnss_frame_receiver_checker_top
  import gfrc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ByteW-1:0]   rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ByteW-1:0]   byte_out_o,
  output logic [KindW-1:0]   field_kind_o,
  output logic [WordW-1:0]   payload_index_o,
  output logic [ByteW-1:0]   msg_class_o,
  output logic [ByteW-1:0]   msg_id_o,
  output logic [WordW-1:0]   frame_length_o,
  output logic               frame_end_o,
  output logic [StatW-1:0]   frame_status_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [WordW-1:0]   cfg_wdata_i
);

`include "gnss_frame_receiver_checker_top_macros.svh"

  typedef enum logic [3:0] {
    PH_HUNT,
    PH_SYNC2,
    PH_CLASS,
    PH_ID,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD,
    PH_CK_A,
    PH_CK_B
  } phase_e;

  // Configuration registers.
  logic [ByteW-1:0] sync_first_q, sync_second_q;
  logic [WordW-1:0] max_len_q;

  // Parser state.
  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] sum_a_q, sum_a_d, sum_b_q, sum_b_d;
  logic [ByteW-1:0] class_q, class_d, id_q, id_d, rx_sum_a_q, rx_sum_a_d;
  logic [WordW-1:0] length_q, length_d, count_q, count_d;

  // Output register and skid register.
  result_t out_q, skid_q, res;
  logic    out_valid_q, skid_valid_q;

  logic in_fire, out_take, out_free;
  logic show_frame;
  logic [ByteW-1:0] acc_a, acc_b;
  logic [WordW-1:0] len_full, count_inc;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_take   = out_valid_q && out_ready_i;
  assign out_free   = out_take || !out_valid_q;

  // Fletcher step on the incoming byte.
  assign acc_a     = sum_a_q + rx_byte_i;
  assign acc_b     = sum_b_q + acc_a;
  assign len_full  = {rx_byte_i, length_q[ByteW-1:0]};
  assign count_inc = count_q + 16'd1;

  always_comb begin
    phase_d    = phase_q;
    sum_a_d    = sum_a_q;
    sum_b_d    = sum_b_q;
    class_d    = class_q;
    id_d       = id_q;
    length_d   = length_q;
    count_d    = count_q;
    rx_sum_a_d = rx_sum_a_q;
    show_frame = 1'b1;
    res              = '0;
    res.byte_out     = rx_byte_i;
    res.field_kind   = KIND_HUNT;
    res.frame_status = ST_PROGRESS;

    case (phase_q)
      PH_HUNT: begin
        show_frame = 1'b0;
        if (rx_byte_i == sync_first_q) begin
          res.field_kind = KIND_SYNC;
          phase_d        = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        show_frame = 1'b0;
        if (rx_byte_i == sync_second_q) begin
          res.field_kind = KIND_SYNC;
          sum_a_d  = '0;
          sum_b_d  = '0;
          class_d  = '0;
          id_d     = '0;
          length_d = '0;
          count_d  = '0;
          phase_d  = PH_CLASS;
        end else if (rx_byte_i == sync_first_q) begin
          res.field_kind = KIND_SYNC;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_CLASS: begin
        res.field_kind = KIND_CLASS;
        class_d = rx_byte_i;
        sum_a_d = acc_a;
        sum_b_d = acc_b;
        phase_d = PH_ID;
      end
      PH_ID: begin
        res.field_kind = KIND_ID;
        id_d    = rx_byte_i;
        sum_a_d = acc_a;
        sum_b_d = acc_b;
        phase_d = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        res.field_kind = KIND_LENGTH;
        length_d = {{(WordW-ByteW){1'b0}}, rx_byte_i};
        sum_a_d  = acc_a;
        sum_b_d  = acc_b;
        phase_d  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        res.field_kind = KIND_LENGTH;
        length_d = len_full;
        sum_a_d  = acc_a;
        sum_b_d  = acc_b;
        count_d  = '0;
        if (len_full > max_len_q) begin
          res.frame_end    = 1'b1;
          res.frame_status = ST_TOOLONG;
          phase_d          = PH_HUNT;
        end else if (len_full == '0) begin
          phase_d = PH_CK_A;
        end else begin
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res.field_kind    = KIND_PAYLOAD;
        res.payload_index = count_q;
        sum_a_d = acc_a;
        sum_b_d = acc_b;
        count_d = count_inc;
        if (count_inc >= length_q) begin
          phase_d = PH_CK_A;
        end
      end
      PH_CK_A: begin
        res.field_kind = KIND_CK;
        rx_sum_a_d = rx_byte_i;
        phase_d    = PH_CK_B;
      end
      PH_CK_B: begin
        res.field_kind = KIND_CK;
        res.frame_end  = 1'b1;
        res.frame_status = (rx_sum_a_q == sum_a_q && rx_byte_i == sum_b_q) ?
                           ST_GOOD : ST_BAD;
        phase_d = PH_HUNT;
      end
      default: begin
        show_frame = 1'b0;
        phase_d    = PH_HUNT;
      end
    endcase

    // Header fields are shown as updated by this byte, once a frame is open.
    res.msg_class    = show_frame ? class_d : '0;
    res.msg_id       = show_frame ? id_d : '0;
    res.frame_length = show_frame ? length_d : '0;
  end

  // Configuration writes; an index past the register list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SYNC_FIRST_RST;
      sync_second_q <= SYNC_SECOND_RST;
      max_len_q     <= MAX_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SYNC_FIRST:  sync_first_q  <= cfg_wdata_i[ByteW-1:0];
        CFG_SYNC_SECOND: sync_second_q <= cfg_wdata_i[ByteW-1:0];
        CFG_MAX_LENGTH:  max_len_q     <= cfg_wdata_i;
        default:         max_len_q     <= max_len_q;
      endcase
    end
  end

  // Parser state advances on every accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      sum_a_q    <= '0;
      sum_b_q    <= '0;
      class_q    <= '0;
      id_q       <= '0;
      length_q   <= '0;
      count_q    <= '0;
      rx_sum_a_q <= '0;
    end else if (in_fire) begin
      phase_q    <= phase_d;
      sum_a_q    <= sum_a_d;
      sum_b_q    <= sum_b_d;
      class_q    <= class_d;
      id_q       <= id_d;
      length_q   <= length_d;
      count_q    <= count_d;
      rx_sum_a_q <= rx_sum_a_d;
    end
  end

  // Valid flags of the output and skid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_fire) begin
        out_q <= res;
      end
    end else if (in_fire) begin
      skid_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign byte_out_o      = out_q.byte_out;
  assign field_kind_o    = out_q.field_kind;
  assign payload_index_o = out_q.payload_index;
  assign msg_class_o     = out_q.msg_class;
  assign msg_id_o        = out_q.msg_id;
  assign frame_length_o  = out_q.frame_length;
  assign frame_end_o     = out_q.frame_end;
  assign frame_status_o  = out_q.frame_status;

  // The skid register only fills behind a held output register.
  `GFRC_ASSERT_IMPL(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  // A byte taken into an empty output stage shows up in the next cycle.
  `GFRC_ASSERT_NEXT(a_fill_empty, clk_i, rst_ni, in_fire && !out_valid_q, out_valid_q)
  // Only the high length byte or the second checksum byte can close a frame.
  `GFRC_ASSERT_IMPL(a_end_kind, clk_i, rst_ni, out_valid_q && out_q.frame_end,
                    out_q.field_kind == KIND_LENGTH || out_q.field_kind == KIND_CK)
  // A status is reported exactly on a frame end.
  `GFRC_ASSERT_IMPL(a_end_status, clk_i, rst_ni, out_valid_q,
                    out_q.frame_end == (out_q.frame_status != ST_PROGRESS))
  // Payload positions appear only on payload bytes.
  `GFRC_ASSERT_IMPL(a_index_kind, clk_i, rst_ni, out_valid_q && out_q.payload_index != '0,
                    out_q.field_kind == KIND_PAYLOAD)

endmodule
